>>> src/dll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_pkg
// Types, sizes and helpers shared by the linked list manager modules.
// ----------------------------------------------------------------------------
package dll_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LINK_W   = IDX_W + 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;

    localparam logic [LINK_W-1:0] LINK_NULL = '1;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_PREPEND = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_DUMP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FIX_PREV,
        S_FIX_NEXT,
        S_LINK
    } state_t;

    typedef struct packed {
        op_t                     op;
        logic signed [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_t                 status;
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        position;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [LINK_W-1:0]       next;
        logic [LINK_W-1:0]       prev;
    } node_t;

    // Node store access: one read port, one write port with per-field enables
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             we_value;
        logic             we_next;
        logic             we_prev;
        logic [IDX_W-1:0] wr_addr;
        node_t            wr_data;
    } mem_req_t;

    typedef struct packed {
        logic             take;
        logic             give;
        logic [IDX_W-1:0] idx;
    } fm_req_t;

    function automatic logic link_ok(input logic [LINK_W-1:0] link);
        return link < LINK_W'(CAPACITY);
    endfunction

endpackage

>>> src/dll_node_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_node_ram
// Node store: value, forward link and backward link per entry, registered read.
// ----------------------------------------------------------------------------
module dll_node_ram
    import dll_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output node_t    rd_data
);

    logic signed [VAL_W-1:0] value_mem [CAPACITY];
    logic [LINK_W-1:0]       next_mem  [CAPACITY];
    logic [LINK_W-1:0]       prev_mem  [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we_value)
        begin
            value_mem[req.wr_addr] <= req.wr_data.value;
        end
        if (req.we_next)
        begin
            next_mem[req.wr_addr] <= req.wr_data.next;
        end
        if (req.we_prev)
        begin
            prev_mem[req.wr_addr] <= req.wr_data.prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data.value <= value_mem[req.rd_addr];
            rd_data.next  <= next_mem[req.rd_addr];
            rd_data.prev  <= prev_mem[req.rd_addr];
        end
    end

endmodule

>>> src/dll_free_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_free_map
// One bit per store entry, set when free; offers the lowest free entry.
// ----------------------------------------------------------------------------
module dll_free_map
    import dll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fm_req_t          req,
    output logic             free_any,
    output logic [IDX_W-1:0] free_idx
);

    logic [CAPACITY-1:0] free_reg;
    logic [CAPACITY-1:0] free_next;

    always_comb
    begin
        free_next = free_reg;
        if (req.take)
        begin
            free_next[req.idx] = 1'b0;
        end
        if (req.give)
        begin
            free_next[req.idx] = 1'b1;
        end
    end

    // Lowest set bit wins
    always_comb
    begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign free_any = |free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else
        begin
            free_reg <= free_next;
        end
    end

endmodule

>>> src/dll_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_ctrl
// Sequencer: head, tail and count registers, list walk, link patching, results.
// ----------------------------------------------------------------------------
module dll_ctrl
    import dll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  in_item_t         cmd,
    output logic             busy,
    output logic             result_strobe,
    output out_item_t        result,
    output mem_req_t         mem_req,
    input  node_t            rd_data,
    output fm_req_t          fm_req,
    input  logic             free_any,
    input  logic [IDX_W-1:0] free_idx
);

    state_t                  state_reg,  state_next;
    logic [LINK_W-1:0]       head_reg,   head_next;
    logic [LINK_W-1:0]       tail_reg,   tail_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic [IDX_W-1:0]        cur_reg,    cur_next;
    logic [CNT_W-1:0]        pos_reg,    pos_next;
    op_t                     op_reg,     op_next;
    logic signed [VAL_W-1:0] val_reg,    val_next;
    logic [LINK_W-1:0]       nx_reg,     nx_next;
    logic [LINK_W-1:0]       pv_reg,     pv_next;
    logic [IDX_W-1:0]        link_reg,   link_next;
    logic [IDX_W-1:0]        new_reg,    new_next;
    logic                    strobe_reg, strobe_next;
    out_item_t               res_reg,    res_next;

    logic             list_empty;
    logic             store_full;
    logic             can_walk;
    logic [CNT_W-1:0] pos_inc;
    logic             walk_more;
    logic             hit;
    logic [LINK_W-1:0] rm_head;
    logic [LINK_W-1:0] rm_tail;

    function automatic out_item_t make_result(
        input status_t                 st,
        input logic signed [VAL_W-1:0] v,
        input logic [CNT_W-1:0]        p,
        input logic [CNT_W-1:0]        c,
        input logic                    l
    );
        out_item_t r;
        r.status    = st;
        r.value_out = v;
        r.position  = POS_W'(p);
        r.count     = COUNT_W'(c);
        r.last      = l;
        return r;
    endfunction

    assign list_empty = !link_ok(head_reg) || !link_ok(tail_reg);
    assign store_full = (count_reg >= CNT_W'(CAPACITY)) || !free_any;
    assign can_walk   = link_ok(head_reg) && (count_reg != '0);
    assign pos_inc    = CNT_W'(pos_reg + 1'b1);
    assign walk_more  = link_ok(rd_data.next) && (pos_inc < count_reg);
    assign hit        = (rd_data.value == val_reg);

    // Unlink of the node under the walk: new ends of the list
    always_comb
    begin
        rm_head = link_ok(rd_data.prev) ? head_reg : rd_data.next;
        rm_tail = link_ok(rd_data.next) ? tail_reg : rd_data.prev;
        if (!link_ok(rm_head) || !link_ok(rm_tail))
        begin
            rm_head = LINK_NULL;
            rm_tail = LINK_NULL;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        OP_APPEND, OP_PREPEND:
                        begin
                            if (!store_full && !list_empty)
                            begin
                                state_next = S_LINK;
                            end
                        end
                        OP_REMOVE, OP_DUMP:
                        begin
                            if (can_walk)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (op_reg == OP_REMOVE && hit)
                begin
                    state_next = S_FIX_PREV;
                end
                else if (!walk_more)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIX_PREV:
            begin
                state_next = S_FIX_NEXT;
            end
            S_FIX_NEXT:
            begin
                state_next = S_IDLE;
            end
            S_LINK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        nx_next     = nx_reg;
        pv_next     = pv_reg;
        link_next   = link_reg;
        new_next    = new_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        mem_req     = '0;
        fm_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.op;
                    val_next = cmd.value;
                    case (cmd.op)
                        OP_APPEND, OP_PREPEND:
                        begin
                            strobe_next = 1'b1;
                            if (store_full)
                            begin
                                res_next = make_result(ST_FULL, cmd.value, '0, count_reg, 1'b1);
                            end
                            else
                            begin
                                fm_req.take            = 1'b1;
                                fm_req.idx             = free_idx;
                                mem_req.we_value       = 1'b1;
                                mem_req.we_next        = 1'b1;
                                mem_req.we_prev        = 1'b1;
                                mem_req.wr_addr        = free_idx;
                                mem_req.wr_data.value  = cmd.value;
                                mem_req.wr_data.next   = LINK_NULL;
                                mem_req.wr_data.prev   = LINK_NULL;
                                new_next               = free_idx;
                                count_next             = CNT_W'(count_reg + 1'b1);
                                if (list_empty)
                                begin
                                    head_next = {1'b0, free_idx};
                                    tail_next = {1'b0, free_idx};
                                end
                                else if (cmd.op == OP_APPEND)
                                begin
                                    mem_req.wr_data.prev = tail_reg;
                                    link_next            = tail_reg[IDX_W-1:0];
                                    tail_next            = {1'b0, free_idx};
                                end
                                else
                                begin
                                    mem_req.wr_data.next = head_reg;
                                    link_next            = head_reg[IDX_W-1:0];
                                    head_next            = {1'b0, free_idx};
                                end
                                res_next = make_result(ST_OK, cmd.value,
                                    (cmd.op == OP_APPEND) ? count_reg : '0,
                                    CNT_W'(count_reg + 1'b1), 1'b1);
                            end
                        end
                        OP_REMOVE, OP_DUMP:
                        begin
                            if (can_walk)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = head_reg[IDX_W-1:0];
                                cur_next        = head_reg[IDX_W-1:0];
                                pos_next        = '0;
                            end
                            else
                            begin
                                strobe_next = 1'b1;
                                res_next    = make_result(ST_MISS, cmd.value, '0, count_reg, 1'b1);
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (op_reg == OP_REMOVE)
                begin
                    if (hit)
                    begin
                        nx_next     = rd_data.next;
                        pv_next     = rd_data.prev;
                        head_next   = rm_head;
                        tail_next   = rm_tail;
                        fm_req.give = 1'b1;
                        fm_req.idx  = cur_reg;
                        count_next  = CNT_W'(count_reg - 1'b1);
                        strobe_next = 1'b1;
                        res_next    = make_result(ST_OK, val_reg, pos_reg,
                                                  CNT_W'(count_reg - 1'b1), 1'b1);
                    end
                    else if (walk_more)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = rd_data.next[IDX_W-1:0];
                        cur_next        = rd_data.next[IDX_W-1:0];
                        pos_next        = pos_inc;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                        res_next    = make_result(ST_MISS, val_reg, '0, count_reg, 1'b1);
                    end
                end
                else
                begin
                    strobe_next = 1'b1;
                    res_next    = make_result(ST_OK, rd_data.value, pos_reg, count_reg,
                                              !walk_more);
                    if (walk_more)
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = rd_data.next[IDX_W-1:0];
                        cur_next        = rd_data.next[IDX_W-1:0];
                        pos_next        = pos_inc;
                    end
                end
            end
            S_FIX_PREV:
            begin
                if (link_ok(pv_reg))
                begin
                    mem_req.we_next      = 1'b1;
                    mem_req.wr_addr      = pv_reg[IDX_W-1:0];
                    mem_req.wr_data.next = nx_reg;
                end
            end
            S_FIX_NEXT:
            begin
                if (link_ok(nx_reg))
                begin
                    mem_req.we_prev      = 1'b1;
                    mem_req.wr_addr      = nx_reg[IDX_W-1:0];
                    mem_req.wr_data.prev = pv_reg;
                end
            end
            S_LINK:
            begin
                // Hook the new node onto the old end of the list
                mem_req.wr_addr = link_reg;
                if (op_reg == OP_APPEND)
                begin
                    mem_req.we_next      = 1'b1;
                    mem_req.wr_data.next = {1'b0, new_reg};
                end
                else
                begin
                    mem_req.we_prev      = 1'b1;
                    mem_req.wr_data.prev = {1'b0, new_reg};
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= LINK_NULL;
            tail_reg   <= LINK_NULL;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pos_reg  <= pos_next;
        op_reg   <= op_next;
        val_reg  <= val_next;
        nx_reg   <= nx_next;
        pv_reg   <= pv_next;
        link_reg <= link_next;
        new_reg  <= new_next;
        res_reg  <= res_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = res_reg;

endmodule

>>> src/doubly_linked_list_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Bounded doubly linked list of signed 32-bit values in a node store.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every result appears
// for one cycle with result_strobe and cannot be held off. Results are
// registered and appear in the cycle after the step that makes them. Append
// and prepend finish in the idle step on an empty list or a full store, and
// otherwise go on to a link step that patches the old end node. Remove reads
// the head, walks one node per step and, on a hit, patches the links in
// S_FIX_PREV and S_FIX_NEXT. Dump walks the list and delivers one element per
// cycle. The single read port of the node store sets the walk at one node per
// cycle. A new node takes the lowest free entry.
module doubly_linked_list_manager
    import dll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  cmd,
    output logic      busy,
    output logic      result_strobe,
    output out_item_t result
);

    mem_req_t         mem_req;
    node_t            rd_data;
    fm_req_t          fm_req;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;

    dll_node_ram u_node_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    dll_free_map u_free_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (fm_req),
        .free_any (free_any),
        .free_idx (free_idx)
    );

    dll_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result),
        .mem_req       (mem_req),
        .rd_data       (rd_data),
        .fm_req        (fm_req),
        .free_any      (free_any),
        .free_idx      (free_idx)
    );

endmodule

>>> src/dll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_checker
// Port-level checks on the linked list manager, bound to the top level.
// ----------------------------------------------------------------------------
module dll_checker
    import dll_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input in_item_t  cmd,
    input logic      busy,
    input logic      result_strobe,
    input out_item_t result
);

    // Append and prepend answer in the very next cycle with a single result
    a_insert_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.op == OP_APPEND || cmd.op == OP_PREPEND)
        |=> result_strobe && result.last)
        else $error("insert item did not answer in the next cycle");

    // A full store means the list holds every entry
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status == ST_FULL
        |-> result.count == COUNT_W'(CAPACITY))
        else $error("full status with a count below capacity");

    // A miss is always a single result at position zero
    a_miss_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status == ST_MISS
        |-> result.last && result.position == '0)
        else $error("miss result not final or not at position zero");

    // Dump elements stream without gaps until the final one
    a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.last
        |=> result_strobe && result.position == POS_W'($past(result.position) + 1'b1))
        else $error("dump stream broken");

endmodule

bind doubly_linked_list_manager dll_checker u_dll_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .cmd           (cmd),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);
